>>> design/voxel_occupancy_query_unit_defines.svh
// Assertion macros used by the checker file of the occupancy query unit.
`ifndef VOXEL_OCCUPANCY_QUERY_UNIT_DEFINES_SVH
`define VOXEL_OCCUPANCY_QUERY_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define VOQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voq checker: same-cycle property failed");

// Check a consequence in the cycle after its antecedent.
`define VOQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voq checker: next-cycle property failed");

`endif

>>> design/voq_pkg.sv
package voq_pkg;

    // Default grid geometry
    localparam int SIZE_X_DEF = 64;
    localparam int SIZE_Y_DEF = 64;
    localparam int SIZE_Z_DEF = 16;

    // Bitmap store
    localparam int STORE_BYTES = 8192;
    localparam int STORE_CELLS = 65536;
    localparam int BYTE_AW     = 13;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int COORD_W    = 32;
    localparam int CELL_IDX_W = 17;
    localparam int TOTAL_W    = 17;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Register reset values
    localparam logic signed [31:0] COS_SCALED_RESET = 32'sd65536;
    localparam logic signed [31:0] SIN_SCALED_RESET = 32'sd0;
    localparam logic [30:0]        Z_SCALE_RESET    = 31'd65536;
    localparam logic signed [31:0] OFFSET_RESET     = 32'sd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY_POINT = 2'd0,
        CMD_QUERY_INDEX = 2'd1,
        CMD_WRITE_BYTE  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_COS_SCALED = 3'd0,
        REG_SIN_SCALED = 3'd1,
        REG_Z_SCALE    = 3'd2,
        REG_OFFSET_X   = 3'd3,
        REG_OFFSET_Y   = 3'd4,
        REG_OFFSET_Z   = 3'd5,
        REG_MAP_VALID  = 3'd6
    } reg_idx_t;

    // Fields that ride along the coordinate pipeline untouched
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [CELL_IDX_W-1:0] cell_index;
        logic [BYTE_AW-1:0]    byte_index;
        logic [7:0]            byte_value;
    } side_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

>>> design/voq_item_if.sv
interface voq_item_if;
    logic                                valid;
    logic                                ready;
    logic [voq_pkg::CMD_W-1:0]           cmd;
    logic signed [voq_pkg::COORD_W-1:0]  point_x;
    logic signed [voq_pkg::COORD_W-1:0]  point_y;
    logic signed [voq_pkg::COORD_W-1:0]  point_z;
    logic [voq_pkg::CELL_IDX_W-1:0]      cell_index;
    logic [voq_pkg::BYTE_AW-1:0]         byte_index;
    logic [7:0]                          byte_value;

    modport source (
        output valid, cmd, point_x, point_y, point_z, cell_index, byte_index, byte_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, point_x, point_y, point_z, cell_index, byte_index, byte_value,
        output ready
    );
endinterface

>>> design/voq_result_if.sv
interface voq_result_if;
    logic                          valid;
    logic                          ready;
    logic                          occupied;
    logic                          out_of_range;
    logic [voq_pkg::TOTAL_W-1:0]   occupied_total;

    modport source (
        output valid, occupied, out_of_range, occupied_total,
        input  ready
    );

    modport sink (
        input  valid, occupied, out_of_range, occupied_total,
        output ready
    );
endinterface

>>> design/voxel_occupancy_query_unit.sv
// Occupancy grid query unit.
// item (sink): one word per command - query a planning-frame point, query a
//   linear cell index, or write one bitmap byte (eight cells). A word is taken
//   when valid and ready are both high.
// result (source): exactly one word per item, in item order: occupied,
//   out_of_range and the running occupied-cell total.
// APB port: rotation/scale, offsets and map_valid; write only while idle.
// Stages: input register, multiply, sum, range check, address, bitmap read,
//   result reg. Throughput: one item per cycle unless result.ready or the sweep
//   holds it; the bitmap has one write and one read port, and a byte write is
//   forwarded to a read of the same byte right behind it.
// Reset: configuration returns to its defaults, the occupied count clears,
//   and a sweep zeroes all 8192 bitmap bytes, one byte a cycle; item.ready
//   stays low until the sweep ends. APB writes are taken throughout.
// Stall: a held result keeps its word; the stages behind it keep filling,
//   so up to six more items are taken before item.ready drops.
module voxel_occupancy_query_unit #(
    parameter int SIZE_X = voq_pkg::SIZE_X_DEF,
    parameter int SIZE_Y = voq_pkg::SIZE_Y_DEF,
    parameter int SIZE_Z = voq_pkg::SIZE_Z_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    voq_item_if.sink                      item,
    voq_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [voq_pkg::PADDR_W-1:0]   paddr,
    input  logic [voq_pkg::PDATA_W-1:0]   pwdata,
    output logic [voq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int GRID_CELLS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int LIMIT      = (GRID_CELLS < voq_pkg::STORE_CELLS) ?
                                GRID_CELLS : voq_pkg::STORE_CELLS;
    localparam int NBYTES     = (LIMIT + 7) / 8;
    localparam int TAIL_BITS  = LIMIT - 8 * (NBYTES - 1);
    localparam logic [7:0] TAIL_MASK = 8'((9'd1 << TAIL_BITS) - 9'd1);

    localparam int XW       = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int YW       = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
    localparam int ZW       = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int ZYW      = $clog2(SIZE_Z * SIZE_Y + 1);
    localparam int LIN_BITS = $clog2(GRID_CELLS + 1);
    localparam int IDX_W    = (LIN_BITS > voq_pkg::CELL_IDX_W) ? LIN_BITS : voq_pkg::CELL_IDX_W;
    localparam int AW       = voq_pkg::BYTE_AW;
    localparam int TW       = voq_pkg::TOTAL_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0]  cos_scaled_reg;
    logic signed [31:0]  sin_scaled_reg;
    logic [30:0]         z_scale_reg;
    logic signed [31:0]  offset_x_reg;
    logic signed [31:0]  offset_y_reg;
    logic signed [31:0]  offset_z_reg;
    logic                map_valid_reg;
    logic                cfg_wr;
    voq_pkg::reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = voq_pkg::reg_idx_t'(paddr[voq_pkg::PADDR_W-1:2]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_scaled_reg <= voq_pkg::COS_SCALED_RESET;
            sin_scaled_reg <= voq_pkg::SIN_SCALED_RESET;
            z_scale_reg    <= voq_pkg::Z_SCALE_RESET;
            offset_x_reg   <= voq_pkg::OFFSET_RESET;
            offset_y_reg   <= voq_pkg::OFFSET_RESET;
            offset_z_reg   <= voq_pkg::OFFSET_RESET;
            map_valid_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                voq_pkg::REG_COS_SCALED: cos_scaled_reg <= pwdata;
                voq_pkg::REG_SIN_SCALED: sin_scaled_reg <= pwdata;
                voq_pkg::REG_Z_SCALE:    z_scale_reg    <= pwdata[30:0];
                voq_pkg::REG_OFFSET_X:   offset_x_reg   <= pwdata;
                voq_pkg::REG_OFFSET_Y:   offset_y_reg   <= pwdata;
                voq_pkg::REG_OFFSET_Z:   offset_z_reg   <= pwdata;
                voq_pkg::REG_MAP_VALID:  map_valid_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            voq_pkg::REG_COS_SCALED: prdata = cos_scaled_reg;
            voq_pkg::REG_SIN_SCALED: prdata = sin_scaled_reg;
            voq_pkg::REG_Z_SCALE:    prdata = {1'b0, z_scale_reg};
            voq_pkg::REG_OFFSET_X:   prdata = offset_x_reg;
            voq_pkg::REG_OFFSET_Y:   prdata = offset_y_reg;
            voq_pkg::REG_OFFSET_Z:   prdata = offset_z_reg;
            voq_pkg::REG_MAP_VALID:  prdata = {31'd0, map_valid_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage moves when the one ahead frees up
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic out_valid_reg;
    logic mv2, mv3, mv4, mv5, mv6, mv_out;
    logic in_fire;
    logic clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    assign mv_out = s6_valid_reg && (!out_valid_reg || result.ready);
    assign mv6    = s5_valid_reg && (!s6_valid_reg || mv_out);
    assign mv5    = s4_valid_reg && (!s5_valid_reg || mv6);
    assign mv4    = s3_valid_reg && (!s4_valid_reg || mv5);
    assign mv3    = s2_valid_reg && (!s3_valid_reg || mv4);
    assign mv2    = s1_valid_reg && (!s2_valid_reg || mv3);

    assign item.ready = !clr_busy_reg && (!s1_valid_reg || mv2);
    assign in_fire    = item.valid && item.ready;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (mv2)
                s1_valid_reg <= 1'b0;

            if (mv2)
                s2_valid_reg <= 1'b1;
            else if (mv3)
                s2_valid_reg <= 1'b0;

            if (mv3)
                s3_valid_reg <= 1'b1;
            else if (mv4)
                s3_valid_reg <= 1'b0;

            if (mv4)
                s4_valid_reg <= 1'b1;
            else if (mv5)
                s4_valid_reg <= 1'b0;

            if (mv5)
                s5_valid_reg <= 1'b1;
            else if (mv6)
                s5_valid_reg <= 1'b0;

            if (mv6)
                s6_valid_reg <= 1'b1;
            else if (mv_out)
                s6_valid_reg <= 1'b0;

            if (mv_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    voq_pkg::side_t     s1_side_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg              <= item.point_x;
            s1_py_reg              <= item.point_y;
            s1_pz_reg              <= item.point_z;
            s1_side_reg.cmd        <= item.cmd;
            s1_side_reg.cell_index <= item.cell_index;
            s1_side_reg.byte_index <= item.byte_index;
            s1_side_reg.byte_value <= item.byte_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation and scale products, Q32.32
    // ------------------------------------------------------------------
    logic signed [63:0] p_cx_next, p_sy_next, p_sx_next, p_cy_next, p_kz_next;
    logic signed [63:0] s2_cx_reg, s2_sy_reg, s2_sx_reg, s2_cy_reg, s2_kz_reg;
    voq_pkg::side_t     s2_side_reg;

    assign p_cx_next = s1_px_reg * cos_scaled_reg;
    assign p_sy_next = s1_py_reg * sin_scaled_reg;
    assign p_sx_next = s1_px_reg * sin_scaled_reg;
    assign p_cy_next = s1_py_reg * cos_scaled_reg;
    assign p_kz_next = $signed({1'b0, z_scale_reg}) * s1_pz_reg;

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            s2_cx_reg   <= p_cx_next;
            s2_sy_reg   <= p_sy_next;
            s2_sx_reg   <= p_sx_next;
            s2_cy_reg   <= p_cy_next;
            s2_kz_reg   <= p_kz_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add offsets and floor to whole cells
    // ------------------------------------------------------------------
    logic signed [64:0] sum_x, sum_y, sum_z;
    logic [32:0]        s3_gx_reg, s3_gy_reg, s3_gz_reg;
    voq_pkg::side_t     s3_side_reg;

    assign sum_x = {s2_cx_reg[63], s2_cx_reg} - {s2_sy_reg[63], s2_sy_reg}
                 + {{17{offset_x_reg[31]}}, offset_x_reg, 16'd0};
    assign sum_y = {s2_sx_reg[63], s2_sx_reg} + {s2_cy_reg[63], s2_cy_reg}
                 + {{17{offset_y_reg[31]}}, offset_y_reg, 16'd0};
    assign sum_z = {s2_kz_reg[63], s2_kz_reg}
                 + {{17{offset_z_reg[31]}}, offset_z_reg, 16'd0};

    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            s3_gx_reg   <= sum_x[64:32];
            s3_gy_reg   <= sum_y[64:32];
            s3_gz_reg   <= sum_z[64:32];
            s3_side_reg <= s2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: bounds check and z/y part of the linear index
    // ------------------------------------------------------------------
    logic            x_in, y_in, z_in;
    logic [ZYW-1:0]  gzy_next;
    logic            s4_inr_reg;
    logic [ZYW-1:0]  s4_gzy_reg;
    logic [XW-1:0]   s4_gx_reg;
    voq_pkg::side_t  s4_side_reg;

    assign x_in = !s3_gx_reg[32] && (s3_gx_reg[31:0] < 32'(SIZE_X));
    assign y_in = !s3_gy_reg[32] && (s3_gy_reg[31:0] < 32'(SIZE_Y));
    assign z_in = !s3_gz_reg[32] && (s3_gz_reg[31:0] < 32'(SIZE_Z));

    assign gzy_next = ZYW'(s3_gz_reg[ZW-1:0]) * ZYW'(SIZE_Y) + ZYW'(s3_gy_reg[YW-1:0]);

    always_ff @(posedge clk)
    begin
        if (mv4)
        begin
            s4_inr_reg  <= x_in && y_in && z_in;
            s4_gzy_reg  <= gzy_next;
            s4_gx_reg   <= s3_gx_reg[XW-1:0];
            s4_side_reg <= s3_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick the byte address and bit for the command
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] lin;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] sel_cell;
    logic             hit_next;
    logic             wr_ok_next;
    logic [7:0]       wr_val_next;
    logic [AW-1:0]    addr_next;

    logic [voq_pkg::CMD_W-1:0] s5_cmd_reg;
    logic                      s5_hit_reg;
    logic                      s5_wr_ok_reg;
    logic [7:0]                s5_wr_val_reg;
    logic [AW-1:0]             s5_addr_reg;
    logic [2:0]                s5_bitsel_reg;

    assign lin = IDX_W'(s4_gzy_reg) * IDX_W'(SIZE_X) + IDX_W'(s4_gx_reg);
    assign idx = IDX_W'(s4_side_reg.cell_index);

    always_comb
    begin
        hit_next    = 1'b0;
        wr_ok_next  = 1'b0;
        wr_val_next = s4_side_reg.byte_value;
        sel_cell    = lin;
        case (s4_side_reg.cmd)
            voq_pkg::CMD_QUERY_POINT:
            begin
                hit_next = map_valid_reg && s4_inr_reg && (lin < IDX_W'(LIMIT));
            end
            voq_pkg::CMD_QUERY_INDEX:
            begin
                sel_cell = idx;
                hit_next = map_valid_reg && (idx < IDX_W'(LIMIT));
            end
            voq_pkg::CMD_WRITE_BYTE:
            begin
                wr_ok_next = {1'b0, s4_side_reg.byte_index} < (AW + 1)'(NBYTES);
                // drop bits of cells past the grid in the last byte
                if (s4_side_reg.byte_index == AW'(NBYTES - 1))
                    wr_val_next = s4_side_reg.byte_value & TAIL_MASK;
            end
            default: ;
        endcase
        if (s4_side_reg.cmd == voq_pkg::CMD_WRITE_BYTE)
            addr_next = s4_side_reg.byte_index;
        else
            addr_next = sel_cell[AW+2:3];
    end

    always_ff @(posedge clk)
    begin
        if (mv5)
        begin
            s5_cmd_reg    <= s4_side_reg.cmd;
            s5_hit_reg    <= hit_next;
            s5_wr_ok_reg  <= wr_ok_next;
            s5_wr_val_reg <= wr_val_next;
            s5_addr_reg   <= addr_next;
            s5_bitsel_reg <= sel_cell[2:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: bitmap read, with forwarding from the write leaving stage 6
    // ------------------------------------------------------------------
    logic [7:0]                bitmap_mem [voq_pkg::STORE_BYTES];
    logic [7:0]                rd_data_reg;
    logic                      s6_fwd_reg;
    logic [7:0]                s6_fwd_data_reg;
    logic [voq_pkg::CMD_W-1:0] s6_cmd_reg;
    logic                      s6_hit_reg;
    logic                      s6_wr_ok_reg;
    logic [7:0]                s6_wr_val_reg;
    logic [AW-1:0]             s6_addr_reg;
    logic [2:0]                s6_bitsel_reg;
    logic                      s6_is_write;
    logic                      wr_fire;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [7:0]                mem_wdata;

    assign s6_is_write = (s6_cmd_reg == voq_pkg::CMD_WRITE_BYTE) && s6_wr_ok_reg;
    assign wr_fire     = mv_out && s6_is_write;

    assign mem_we    = clr_busy_reg || wr_fire;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s6_addr_reg;
    assign mem_wdata = clr_busy_reg ? 8'd0 : s6_wr_val_reg;

    // Sweep the bitmap to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
                clr_busy_reg <= 1'b0;
        end
    end

    // Bitmap write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bitmap_mem[mem_waddr] <= mem_wdata;
    end

    // Bitmap read port
    always_ff @(posedge clk)
    begin
        if (mv6)
            rd_data_reg <= bitmap_mem[s5_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mv6)
        begin
            s6_fwd_reg      <= wr_fire && (s6_addr_reg == s5_addr_reg);
            s6_fwd_data_reg <= s6_wr_val_reg;
            s6_cmd_reg      <= s5_cmd_reg;
            s6_hit_reg      <= s5_hit_reg;
            s6_wr_ok_reg    <= s5_wr_ok_reg;
            s6_wr_val_reg   <= s5_wr_val_reg;
            s6_addr_reg     <= s5_addr_reg;
            s6_bitsel_reg   <= s5_bitsel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result: cell bit, occupied count and output register
    // ------------------------------------------------------------------
    logic [7:0]    old_byte;
    logic          cell_bit;
    logic [TW-1:0] counter_reg;
    logic [TW-1:0] counter_next;
    logic          occ_next;
    logic          oor_next;
    logic [TW-1:0] total_next;
    logic          occupied_reg;
    logic          out_of_range_reg;
    logic [TW-1:0] occupied_total_reg;

    assign old_byte     = s6_fwd_reg ? s6_fwd_data_reg : rd_data_reg;
    assign cell_bit     = old_byte[s6_bitsel_reg];
    assign counter_next = counter_reg - TW'(voq_pkg::popcount8(old_byte))
                        + TW'(voq_pkg::popcount8(s6_wr_val_reg));

    always_comb
    begin
        occ_next = 1'b1;
        oor_next = 1'b1;
        case (s6_cmd_reg)
            voq_pkg::CMD_QUERY_POINT,
            voq_pkg::CMD_QUERY_INDEX:
            begin
                oor_next = !s6_hit_reg;
                occ_next = s6_hit_reg ? cell_bit : 1'b1;
            end
            voq_pkg::CMD_WRITE_BYTE:
            begin
                oor_next = 1'b0;
                occ_next = 1'b0;
            end
            default: ;
        endcase
        if (!map_valid_reg)
            total_next = '0;
        else if (s6_is_write)
            total_next = counter_next;
        else
            total_next = counter_reg;
    end

    // Hold the running count of occupied cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counter_reg <= '0;
        else if (wr_fire)
            counter_reg <= counter_next;
    end

    always_ff @(posedge clk)
    begin
        if (mv_out)
        begin
            occupied_reg       <= occ_next;
            out_of_range_reg   <= oor_next;
            occupied_total_reg <= total_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.occupied       = occupied_reg;
    assign result.out_of_range   = out_of_range_reg;
    assign result.occupied_total = occupied_total_reg;

endmodule

>>> design/voq_checker.sv
`include "voxel_occupancy_query_unit_defines.svh"

module voq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         result_occupied,
    input logic                         result_out_of_range,
    input logic [voq_pkg::TOTAL_W-1:0]  result_occupied_total
);

    // The bitmap sweep keeps the item side closed right after reset
    `VOQ_ASSERT_NOW(a_no_item_during_sweep, clk, rst_n, $past(!rst_n), !item_ready)

    // Anything off the grid is always reported occupied
    `VOQ_ASSERT_NOW(a_oor_means_occupied, clk, rst_n, result_valid && result_out_of_range, result_occupied)

    // The occupied count never exceeds the cells the store holds
    `VOQ_ASSERT_NOW(a_total_bounded, clk, rst_n, result_valid, result_occupied_total <= voq_pkg::TOTAL_W'(voq_pkg::STORE_CELLS))

    // A stalled result word holds
    `VOQ_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && !result_ready, result_valid && $stable({result_occupied, result_out_of_range, result_occupied_total}))

endmodule

bind voxel_occupancy_query_unit voq_checker u_voq_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .item_ready            (item.ready),
    .result_valid          (result.valid),
    .result_ready          (result.ready),
    .result_occupied       (result.occupied),
    .result_out_of_range   (result.out_of_range),
    .result_occupied_total (result.occupied_total)
);

>>> tb/voxel_occupancy_query_unit_test.sv
`timescale 1ns / 100ps

module voxel_occupancy_query_unit_test;
    import voq_pkg::*;

    // Grid geometry of the instance (package defaults)
    localparam int GX = SIZE_X_DEF;
    localparam int GY = SIZE_Y_DEF;
    localparam int GZ = SIZE_Z_DEF;
    localparam int CELL_LIMIT = (GX * GY * GZ < STORE_CELLS) ? GX * GY * GZ : STORE_CELLS;
    localparam int ONE_M = 65536;
    localparam int QUIET_LIMIT = 40000;
    localparam int LONG_HOLD = 90;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [COORD_W-1:0]    point_x;
        logic [COORD_W-1:0]    point_y;
        logic [COORD_W-1:0]    point_z;
        logic [CELL_IDX_W-1:0] cell_index;
        logic [BYTE_AW-1:0]    byte_index;
        logic [7:0]            byte_value;
    } query_word_t;

    typedef struct packed {
        logic               occupied;
        logic               out_of_range;
        logic [TOTAL_W-1:0] occupied_total;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    voq_item_if   item_ch ();
    voq_result_if result_ch ();

    voxel_occupancy_query_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's state and registers
    logic [7:0]         shadow_bitmap [STORE_BYTES];
    logic [TOTAL_W-1:0] shadow_count;
    logic signed [31:0] cfg_cos;
    logic signed [31:0] cfg_sin;
    logic [30:0]        cfg_zscale;
    logic signed [31:0] cfg_off_x;
    logic signed [31:0] cfg_off_y;
    logic signed [31:0] cfg_off_z;
    logic               cfg_valid;

    query_word_t pending_words[$];
    verdict_t    expected_results[$];
    int          mismatches = 0;
    int          results_checked = 0;
    logic        run_done = 1'b0;
    logic        timed_out = 1'b0;

    // Sender and receiver pacing
    query_word_t in_flight;
    int          burst_left = 0;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_hold_left = 0;
    int          rx_taken = 0;
    logic        long_hold_done = 1'b0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [71:0] widen(input logic signed [31:0] a);
        return a;
    endfunction

    // Compute the result of one word and advance the shadow state
    function automatic verdict_t predict_occupancy(input query_word_t w);
        verdict_t r;
        logic signed [71:0] zk;
        logic signed [71:0] gx;
        logic signed [71:0] gy;
        logic signed [71:0] gz;
        logic [7:0] v;
        int b;
        int first;
        int lin;
        r.occupied = 1'b1;
        r.out_of_range = 1'b1;
        case (w.cmd)
            CMD_WRITE_BYTE:
            begin
                b = w.byte_index;
                if (b < (CELL_LIMIT + 7) / 8)
                begin
                    v = w.byte_value;
                    first = b * 8;
                    if (CELL_LIMIT - first < 8)
                        v = v & 8'((9'd1 << (CELL_LIMIT - first)) - 9'd1);
                    shadow_count = shadow_count - TOTAL_W'($countones(shadow_bitmap[b]))
                                   + TOTAL_W'($countones(v));
                    shadow_bitmap[b] = v;
                end
                r.occupied = 1'b0;
                r.out_of_range = 1'b0;
            end
            CMD_QUERY_INDEX:
            begin
                if (cfg_valid && w.cell_index < CELL_LIMIT)
                begin
                    r.out_of_range = 1'b0;
                    r.occupied = shadow_bitmap[w.cell_index >> 3][w.cell_index % 8];
                end
            end
            CMD_QUERY_POINT:
            begin
                if (cfg_valid)
                begin
                    zk = {41'd0, cfg_zscale};
                    gx = (widen(cfg_cos) * widen($signed(w.point_x))
                          - widen(cfg_sin) * widen($signed(w.point_y))
                          + (widen(cfg_off_x) <<< 16)) >>> 32;
                    gy = (widen(cfg_sin) * widen($signed(w.point_x))
                          + widen(cfg_cos) * widen($signed(w.point_y))
                          + (widen(cfg_off_y) <<< 16)) >>> 32;
                    gz = (zk * widen($signed(w.point_z)) + (widen(cfg_off_z) <<< 16)) >>> 32;
                    if (gx >= 0 && gx < GX && gy >= 0 && gy < GY && gz >= 0 && gz < GZ)
                    begin
                        lin = int'((gz * GY + gy) * GX + gx);
                        if (lin < CELL_LIMIT)
                        begin
                            r.out_of_range = 1'b0;
                            r.occupied = shadow_bitmap[lin >> 3][lin % 8];
                        end
                    end
                end
            end
            default:
            begin
                // reserved command: fail safe, no state change
            end
        endcase
        r.occupied_total = cfg_valid ? shadow_count : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 30)
            $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Word builders; unused fields carry random noise
    function automatic query_word_t blank_word();
        query_word_t w;
        w.cmd = CMD_RESERVED;
        w.point_x = $urandom;
        w.point_y = $urandom;
        w.point_z = $urandom;
        w.cell_index = CELL_IDX_W'($urandom);
        w.byte_index = BYTE_AW'($urandom);
        w.byte_value = 8'($urandom);
        return w;
    endfunction

    function automatic query_word_t point_word(input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz);
        query_word_t w;
        w = blank_word();
        w.cmd = CMD_QUERY_POINT;
        w.point_x = px;
        w.point_y = py;
        w.point_z = pz;
        return w;
    endfunction

    function automatic query_word_t index_word(input int idx);
        query_word_t w;
        w = blank_word();
        w.cmd = CMD_QUERY_INDEX;
        w.cell_index = CELL_IDX_W'(idx);
        return w;
    endfunction

    function automatic query_word_t write_word(input int b, input logic [7:0] v);
        query_word_t w;
        w = blank_word();
        w.cmd = CMD_WRITE_BYTE;
        w.byte_index = BYTE_AW'(b);
        w.byte_value = v;
        return w;
    endfunction

    // Hot region: x in [0,8), y in [0,8), z in [0,4) cells under identity
    function automatic int hot_byte();
        return (int'($urandom_range(0, 3)) * GY + int'($urandom_range(0, 7))) * (GX / 8);
    endfunction

    function automatic logic [31:0] hot_coord(input int span_m);
        return $urandom_range(0, (span_m + 1) * ONE_M - 1) - ONE_M;
    endfunction

    function automatic logic [31:0] any_coord(input int span_m);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return hot_coord(span_m);
        else if (pick < 90)
            return $urandom_range(0, 2 * ONE_M) - ONE_M;
        else
            return $urandom;
    endfunction

    function automatic query_word_t random_word();
        int pick;
        int sel;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (pick < 25)
        begin
            v = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
            if (sel < 7)
                return write_word(hot_byte(), v);
            return write_word(int'($urandom_range(0, STORE_BYTES - 1)), v);
        end
        else if (pick < 65)
            return point_word(any_coord(9), any_coord(9), any_coord(5));
        else if (pick < 92)
        begin
            if (sel < 7)
                return index_word(hot_byte() * 8 + int'($urandom_range(0, 7)));
            else if (sel < 9)
                return index_word(int'($urandom_range(0, CELL_LIMIT - 1)));
            return index_word(int'($urandom_range(0, (1 << CELL_IDX_W) - 1)));
        end
        return blank_word();
    endfunction

    // Append one word to the driver's queue
    task automatic enqueue_word(input query_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        repeat (count)
            enqueue_word(random_word());
    endtask

    // Wait until every word went in and every result came back
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || item_ch.valid || expected_results.size() != 0);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COS_SCALED: cfg_cos = value;
            REG_SIN_SCALED: cfg_sin = value;
            REG_Z_SCALE:    cfg_zscale = value[30:0];
            REG_OFFSET_X:   cfg_off_x = value;
            REG_OFFSET_Y:   cfg_off_y = value;
            REG_OFFSET_Z:   cfg_off_z = value;
            REG_MAP_VALID:  cfg_valid = value[0];
            default:        ;
        endcase
    endtask

    task automatic set_geometry(input logic [31:0] cos_v, input logic [31:0] sin_v,
                                input logic [31:0] zs_v, input logic [31:0] ox,
                                input logic [31:0] oy, input logic [31:0] oz,
                                input logic valid_v);
        apb_write(REG_COS_SCALED, cos_v);
        apb_write(REG_SIN_SCALED, sin_v);
        apb_write(REG_Z_SCALE, zs_v);
        apb_write(REG_OFFSET_X, ox);
        apb_write(REG_OFFSET_Y, oy);
        apb_write(REG_OFFSET_Z, oz);
        apb_write(REG_MAP_VALID, {31'd0, valid_v});
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = '0;
        item_ch.point_x = '0;
        item_ch.point_y = '0;
        item_ch.point_z = '0;
        item_ch.cell_index = '0;
        item_ch.byte_index = '0;
        item_ch.byte_value = '0;
        result_ch.ready = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_bitmap[i] = 8'h00;
        shadow_count = '0;
        cfg_cos = COS_SCALED_RESET;
        cfg_sin = SIN_SCALED_RESET;
        cfg_zscale = Z_SCALE_RESET;
        cfg_off_x = OFFSET_RESET;
        cfg_off_y = OFFSET_RESET;
        cfg_off_z = OFFSET_RESET;
        cfg_valid = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Map invalid after reset: queries fail safe, writes still land
        @(negedge clk);
        enqueue_word(write_word(0, 8'hFF));
        enqueue_word(write_word(STORE_BYTES - 1, 8'h80));
        enqueue_word(index_word(0));
        enqueue_word(point_word(0, 0, 0));
        enqueue_word(blank_word());
        enqueue_word(index_word((1 << CELL_IDX_W) - 1));
        wait_until_drained();

        // Validate the map on reset geometry and walk the edges
        apb_write(REG_MAP_VALID, 32'd1);
        @(negedge clk);
        enqueue_word(index_word(0));
        enqueue_word(index_word(8));
        enqueue_word(index_word(CELL_LIMIT - 1));
        enqueue_word(index_word(CELL_LIMIT - 2));
        enqueue_word(index_word(CELL_LIMIT));
        enqueue_word(index_word((1 << CELL_IDX_W) - 1));
        enqueue_word(point_word(0, 0, 0));
        enqueue_word(point_word(32'hFFFF_FFFF, 0, 0));
        enqueue_word(point_word(GX * ONE_M - 1, GY * ONE_M - 1, GZ * ONE_M - 1));
        enqueue_word(point_word(GX * ONE_M, 0, 0));
        enqueue_word(point_word(0, 0, GZ * ONE_M));
        enqueue_word(point_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        enqueue_word(point_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // write queued right before a read of the same byte
        enqueue_word(write_word(0, 8'h00));
        enqueue_word(index_word(0));
        enqueue_word(write_word(5, 8'hA5));
        enqueue_word(index_word(40));
        enqueue_word(index_word(41));
        enqueue_word(write_word(STORE_BYTES - 1, 8'hFF));
        enqueue_word(point_word(7 * ONE_M + ONE_M / 2, 0, 0));
        enqueue_word(blank_word());
        wait_until_drained();

        // Identity, one cell per meter
        set_geometry(32'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 1'b1);
        queue_random(150);
        wait_until_drained();

        // Quarter turn, two cells per meter in x and y and 1.5 in z, shifted box
        set_geometry(32'd0, 2 * ONE_M, 3 * ONE_M / 2, 32 * ONE_M, 8 * ONE_M, 2 * ONE_M, 1'b1);
        queue_random(120);
        wait_until_drained();

        // Diagonal yaw with a negative sine and a negative z shift
        set_geometry(32'd46341, -32'sd46341, 2 * ONE_M, 4 * ONE_M, 40 * ONE_M, -ONE_M, 1'b1);
        queue_random(120);
        wait_until_drained();

        // Register extremes
        set_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        queue_random(60);
        wait_until_drained();
        set_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        queue_random(50);
        wait_until_drained();

        // Map invalid again
        set_geometry(32'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 1'b0);
        queue_random(60);
        wait_until_drained();

        set_geometry(32'd65536, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 1'b1);
        queue_random(90);
        wait_until_drained();
        run_done = 1'b1;
    end

    // Driver: bursts of words with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                expected_results.insert(expected_results.size(), predict_occupancy(in_flight));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_flight = pending_words.pop_front();
                    item_ch.cmd <= in_flight.cmd;
                    item_ch.point_x <= in_flight.point_x;
                    item_ch.point_y <= in_flight.point_y;
                    item_ch.point_z <= in_flight.point_z;
                    item_ch.cell_index <= in_flight.cell_index;
                    item_ch.byte_index <= in_flight.byte_index;
                    item_ch.byte_value <= in_flight.byte_value;
                    item_ch.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                rx_taken++;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && rx_taken >= 200)
            begin
                long_hold_done = 1'b1;
                rx_hold_left = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(16, 96);
                end
                else
                begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   result_ch.ready <= 1'b1;
                    RX_LIGHT:  result_ch.ready <= ($urandom_range(0, 9) < 7);
                    RX_HEAVY:  result_ch.ready <= ($urandom_range(0, 9) < 3);
                    default:   result_ch.ready <= ~result_ch.ready;
                endcase
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.occupied = result_ch.occupied;
            got.out_of_range = result_ch.out_of_range;
            got.occupied_total = result_ch.occupied_total;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word occ=%0b oor=%0b total=%0d",
                                          got.occupied, got.out_of_range, got.occupied_total));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "word %0d got occ=%0b oor=%0b total=%0d, want occ=%0b oor=%0b total=%0d",
                        results_checked, got.occupied, got.out_of_range, got.occupied_total,
                        want.occupied, want.out_of_range, want.occupied_total));
            end
            results_checked++;
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out <= 1'b1;
        end
    end

    // End of run
    initial
    begin
        @(posedge run_done or posedge timed_out);
        if (!timed_out)
            repeat (12) @(posedge clk);
        if (!timed_out && mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
